### rtl/h2r_pkg.sv
// ----------------------------------------------------------------------------
// h2r_pkg
// Shared constants for the HSV to RGB converter: default fraction width,
// channel width and hue sector codes.
// ----------------------------------------------------------------------------
package h2r_pkg;

	localparam int FRAC_BITS_DEFAULT = 16;
	localparam int CHAN_W            = 8;
	localparam int SECTOR_W          = 3;

	typedef logic [SECTOR_W-1:0] sector_t;

	// Hue sectors, one sixth of a turn each
	localparam sector_t SECT_RED_YELLOW   = 3'd0;
	localparam sector_t SECT_YELLOW_GREEN = 3'd1;
	localparam sector_t SECT_GREEN_CYAN   = 3'd2;
	localparam sector_t SECT_CYAN_BLUE    = 3'd3;
	localparam sector_t SECT_BLUE_MAGENTA = 3'd4;

endpackage

### rtl/h2r_hsv_if.sv
// ----------------------------------------------------------------------------
// h2r_hsv_if
// Valid/ready channel carrying one HSV colour per beat.
// ----------------------------------------------------------------------------
interface h2r_hsv_if
	import h2r_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
);
	logic                 valid;
	logic                 ready;
	logic [FRAC_BITS:0]   hue;
	logic [FRAC_BITS:0]   saturation;
	logic [FRAC_BITS:0]   brightness;

	modport source (output valid, output hue, output saturation, output brightness,
		input ready);
	modport sink (input valid, input hue, input saturation, input brightness,
		output ready);
endinterface

### rtl/h2r_rgb_if.sv
// ----------------------------------------------------------------------------
// h2r_rgb_if
// Valid/ready channel carrying one 8-bit RGB colour per beat.
// ----------------------------------------------------------------------------
interface h2r_rgb_if;
	import h2r_pkg::*;

	logic              valid;
	logic              ready;
	logic [CHAN_W-1:0] red;
	logic [CHAN_W-1:0] green;
	logic [CHAN_W-1:0] blue;

	modport source (output valid, output red, output green, output blue, input ready);
	modport sink (input valid, input red, input green, input blue, output ready);
endinterface

### rtl/hsv_to_rgb_converter_unit.sv
// An accepted HSV beat is registered in stages 1 to 5 before its RGB beat appears.
// Throughput: one beat per cycle; the five stages advance together whenever the
// output register is empty or being taken, so back-pressure stalls the whole pipe.
// Reset: arst_n clears all stage valid bits; no beat is pending after reset.
// ----------------------------------------------------------------------------
// hsv_to_rgb_converter_unit
// Fixed-point HSV to RGB conversion: sector split, p/q/t products, sector
// permutation and scaling to 8-bit channels in a five-stage pipeline.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_unit
	import h2r_pkg::*;
#(
	parameter int FRAC_BITS = FRAC_BITS_DEFAULT
) (
	input  logic            clk,
	input  logic            arst_n,
	h2r_hsv_if.sink         hsv_in,
	h2r_rgb_if.source       rgb_out
);

	localparam int FW = FRAC_BITS + 1;     // fixed-point value up to and including 1.0
	localparam int PW = 2 * FW;            // product of two such values
	localparam int HW = FRAC_BITS + 3;     // hue times six
	localparam int BW = FRAC_BITS + CHAN_W + 1;
	localparam logic [FW-1:0] ONE = {1'b1, {FRAC_BITS{1'b0}}};

	logic adv;

	// stage 1: clamp, hue split
	logic [FRAC_BITS-1:0] hue_frac;
	logic [HW-1:0]        h6;
	logic [FW-1:0]        s_sat, v_sat;

	logic                 vld_s1;
	sector_t              sector_s1;
	logic [FRAC_BITS-1:0] f_s1;
	logic [FW-1:0]        s_s1, v_s1;

	// stage 2: s*f, s*(1-f), p
	logic [PW-1:0]        prod_sf, prod_sif, prod_p;
	logic                 vld_s2;
	sector_t              sector_s2;
	logic [FW-1:0]        sf_s2, sif_s2, p_s2, v_s2;

	// stage 3: q, t
	logic [PW-1:0]        prod_q, prod_t;
	logic                 vld_s3;
	sector_t              sector_s3;
	logic [FW-1:0]        q_s3, t_s3, p_s3, v_s3;

	// stage 4: permutation
	logic [FW-1:0]        r_sel, g_sel, b_sel;
	logic                 vld_s4;
	logic [FW-1:0]        r_s4, g_s4, b_s4;

	// stage 5: scale by 255
	logic [BW-1:0]        r_scl, g_scl, b_scl;
	logic                 vld_s5;
	logic [CHAN_W-1:0]    red_s5, green_s5, blue_s5;

	// advance every stage when the output slot is free or drains this cycle
	assign adv          = !vld_s5 || rgb_out.ready;
	assign hsv_in.ready = adv;

	always_comb begin
		hue_frac = hsv_in.hue[FRAC_BITS-1:0];
		h6       = ({3'b000, hue_frac} << 2) + ({3'b000, hue_frac} << 1);
		s_sat    = (hsv_in.saturation > ONE) ? ONE : hsv_in.saturation;
		v_sat    = (hsv_in.brightness > ONE) ? ONE : hsv_in.brightness;
	end

	always_comb begin
		prod_sf  = s_s1 * {1'b0, f_s1};
		prod_sif = s_s1 * (ONE - {1'b0, f_s1});
		prod_p   = v_s1 * (ONE - s_s1);
	end

	always_comb begin
		prod_q = v_s2 * (ONE - sf_s2);
		prod_t = v_s2 * (ONE - sif_s2);
	end

	always_comb begin
		case (sector_s3)
			SECT_RED_YELLOW: begin
				r_sel = v_s3; g_sel = t_s3; b_sel = p_s3;
			end
			SECT_YELLOW_GREEN: begin
				r_sel = q_s3; g_sel = v_s3; b_sel = p_s3;
			end
			SECT_GREEN_CYAN: begin
				r_sel = p_s3; g_sel = v_s3; b_sel = t_s3;
			end
			SECT_CYAN_BLUE: begin
				r_sel = p_s3; g_sel = q_s3; b_sel = v_s3;
			end
			SECT_BLUE_MAGENTA: begin
				r_sel = t_s3; g_sel = p_s3; b_sel = v_s3;
			end
			default: begin
				r_sel = v_s3; g_sel = p_s3; b_sel = q_s3;
			end
		endcase
	end

	// x * 255 as (x << 8) - x
	always_comb begin
		r_scl = {r_s4, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, r_s4};
		g_scl = {g_s4, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, g_s4};
		b_scl = {b_s4, {CHAN_W{1'b0}}} - {{CHAN_W{1'b0}}, b_s4};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= hsv_in.valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sector_s1 <= h6[HW-1:FRAC_BITS];
			f_s1      <= h6[FRAC_BITS-1:0];
			s_s1      <= s_sat;
			v_s1      <= v_sat;

			sector_s2 <= sector_s1;
			sf_s2     <= prod_sf[FRAC_BITS +: FW];
			sif_s2    <= prod_sif[FRAC_BITS +: FW];
			p_s2      <= prod_p[FRAC_BITS +: FW];
			v_s2      <= v_s1;

			sector_s3 <= sector_s2;
			q_s3      <= prod_q[FRAC_BITS +: FW];
			t_s3      <= prod_t[FRAC_BITS +: FW];
			p_s3      <= p_s2;
			v_s3      <= v_s2;

			r_s4      <= r_sel;
			g_s4      <= g_sel;
			b_s4      <= b_sel;

			red_s5    <= r_scl[FRAC_BITS +: CHAN_W];
			green_s5  <= g_scl[FRAC_BITS +: CHAN_W];
			blue_s5   <= b_scl[FRAC_BITS +: CHAN_W];
		end
	end

	assign rgb_out.valid = vld_s5;
	assign rgb_out.red   = red_s5;
	assign rgb_out.green = green_s5;
	assign rgb_out.blue  = blue_s5;

endmodule
